// ===== sv/ppd_pkg.sv =====
// shared types and constants for the periodic pair distance core
package ppd_pkg;

  localparam int ATOM_SLOTS_DEF = 1024;
  localparam int IDX_W = 10;
  localparam int POS_W = 24;
  localparam int BOX_W = 23;
  localparam int DSQ_W = 50;
  localparam int DIST_W = 25;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic [BOX_W-1:0] BOX_RESET = 23'd409600;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [1:0] CFG_BOX_X = 2'd0;
  localparam logic [1:0] CFG_BOX_Y = 2'd1;
  localparam logic [1:0] CFG_BOX_Z = 2'd2;

  typedef struct packed {
    logic req_type;
    logic [IDX_W-1:0] load_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [IDX_W-1:0] first_atom;
    logic [IDX_W-1:0] second_atom;
  } req_t;

  typedef struct packed {
    logic [DSQ_W-1:0] distance_sq;
    logic [DIST_W-1:0] distance;
  } res_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    pos_t a;
    pos_t b;
  } pair_t;

  typedef struct packed {
    logic empty;
    logic [QCW-1:0] count;
  } qstat_t;

endpackage

// ===== sv/ppd_front.sv =====
// request intake, position store and pair fetch
module ppd_front import ppd_pkg::*; #(
  parameter int ATOM_SLOTS = ATOM_SLOTS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  req_t   req_data,
  input  qstat_t qstat,
  output logic   push,
  output pair_t  push_data
);

  localparam int AW = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;

  pos_t mem [ATOM_SLOTS];
  pos_t rd_a;
  pos_t rd_b;
  logic s1_valid;
  logic va;
  logic vb;
  logic accept;
  logic [16:0] li;
  logic [16:0] fi;
  logic [16:0] si;
  pos_t wpos;

  assign accept = req_valid && !req_stall;
  assign req_stall = ({1'b0, qstat.count} + (QCW+1)'(s1_valid)) >= (QCW+1)'(QDEPTH);
  assign li = 17'(req_data.load_index);
  assign fi = 17'(req_data.first_atom);
  assign si = 17'(req_data.second_atom);
  assign wpos = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};

  always_ff @(posedge clk) begin
    if (accept && req_data.req_type == REQ_LOAD && li < 17'(ATOM_SLOTS)) begin
      mem[li[AW-1:0]] <= wpos;
    end
    rd_a <= mem[fi[AW-1:0]];
    rd_b <= mem[si[AW-1:0]];
    va <= fi < 17'(ATOM_SLOTS);
    vb <= si < 17'(ATOM_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && req_data.req_type == REQ_QUERY;
    end
  end

  assign push = s1_valid;
  assign push_data.a = va ? rd_a : '0;
  assign push_data.b = vb ? rd_b : '0;

endmodule

// ===== sv/ppd_queue.sv =====
// short fifo of fetched pairs between front and back
module ppd_queue import ppd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  pair_t  push_data,
  input  logic   pop,
  output pair_t  head,
  output qstat_t qstat
);

  pair_t entries [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QCW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  assign head = entries[rp];
  assign qstat.count = count;
  assign qstat.empty = (count == '0);

endmodule

// ===== sv/ppd_back.sv =====
// minimum-image wrap, squared sum and bit-serial square root
module ppd_back import ppd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [BOX_W-1:0] box_x,
  input  logic [BOX_W-1:0] box_y,
  input  logic [BOX_W-1:0] box_z,
  input  qstat_t           qstat,
  input  pair_t            head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res_data
);

  localparam int MAG_W = 25;
  localparam int SUM_W = 52;
  localparam int ROOT_STEPS = SUM_W / 2;
  localparam int SC_W = $clog2(ROOT_STEPS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_ROOT, S_OUT} state_t;

  state_t state;
  logic [MAG_W-1:0] mx, my, mz;
  logic [2*MAG_W-1:0] sqx, sqy, sqz;
  logic [SUM_W-1:0] rem, res, bitv;
  logic [SC_W-1:0] steps;
  logic [SUM_W-1:0] trial;

  function automatic logic [MAG_W-1:0] wrap_mag(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b,
                                                input logic [BOX_W-1:0] box);
    logic signed [POS_W+1:0] d;
    logic signed [POS_W+1:0] bx;
    logic signed [POS_W+1:0] w;
    d = (POS_W+2)'(a) - (POS_W+2)'(b);
    bx = $signed({3'b000, box});
    if ((d <<< 1) > bx) begin
      w = d - bx;
    end else if ((d <<< 1) < -bx) begin
      w = d + bx;
    end else begin
      w = d;
    end
    if (w < 0) begin
      w = -w;
    end
    return w[MAG_W-1:0];
  endfunction

  assign pop = (state == S_IDLE) && !qstat.empty;
  assign trial = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            mx <= wrap_mag(head.a.x, head.b.x, box_x);
            my <= wrap_mag(head.a.y, head.b.y, box_y);
            mz <= wrap_mag(head.a.z, head.b.z, box_z);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sqx <= mx * mx;
          sqy <= my * my;
          sqz <= mz * mz;
          state <= S_SUM;
        end
        S_SUM: begin
          rem <= SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz);
          res <= '0;
          bitv <= SUM_W'(1) << (SUM_W - 2);
          steps <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          steps <= steps + 1'b1;
          if (steps == SC_W'(ROOT_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res_data.distance_sq <= DSQ_W'(SUM_W'(sqx) + SUM_W'(sqy) + SUM_W'(sqz));
            res_data.distance <= res[DIST_W-1:0];
            res_valid <= 1'b1;
          end else if (!res_stall) begin
            res_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/periodic_pair_distance_core.sv =====
// top level of the periodic pair distance core
// Load requests write one atom slot and are taken one per cycle while the pair
// queue has room. A pair query is read from the two-read position store into
// registers and queued; the back end then takes it through wrap, square, sum,
// then one square-root bit pair per cycle, then output, plus however long the
// result is stalled, and takes no new pair until that result is delivered. Up
// to four fetched queries wait while a result is pending.
module periodic_pair_distance_core import ppd_pkg::*; #(
  parameter int ATOM_SLOTS = ATOM_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [BOX_W-1:0] cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req_data,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res_data
);

  logic [BOX_W-1:0] box_x, box_y, box_z;
  qstat_t qstat;
  logic push;
  logic pop;
  pair_t push_data;
  pair_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x <= BOX_RESET;
      box_y <= BOX_RESET;
      box_z <= BOX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X: box_x <= cfg_data;
        CFG_BOX_Y: box_y <= cfg_data;
        CFG_BOX_Z: box_z <= cfg_data;
        default: ;
      endcase
    end
  end

  ppd_front #(.ATOM_SLOTS(ATOM_SLOTS)) u_front (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req_data(req_data), .qstat(qstat), .push(push), .push_data(push_data)
  );

  ppd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .head(head), .qstat(qstat)
  );

  ppd_back u_back (
    .clk(clk), .rst(rst), .box_x(box_x), .box_y(box_y), .box_z(box_z),
    .qstat(qstat), .head(head), .pop(pop), .res_valid(res_valid),
    .res_stall(res_stall), .res_data(res_data)
  );

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> qstat.count < QCW'(QDEPTH))
    else $error("pair queue overflow");

  a_res_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall |=> !res_valid)
    else $error("result repeated after delivery");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> 64'(res_data.distance) * 64'(res_data.distance) <=
                  64'(res_data.distance_sq))
    else $error("root exceeds squared distance");
`endif

endmodule

// ===== tb/tb_top.sv =====
// testbench for the periodic pair distance core: loads, pair queries, box settings
module tb_top;
  import ppd_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [BOX_W-1:0] cfg_data;
  logic req_valid;
  logic req_stall;
  req_t req_data;
  logic res_valid;
  logic res_stall;
  res_t res_data;

  periodic_pair_distance_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  logic signed [POS_W-1:0] atom_x [ATOM_SLOTS_DEF];
  logic signed [POS_W-1:0] atom_y [ATOM_SLOTS_DEF];
  logic signed [POS_W-1:0] atom_z [ATOM_SLOTS_DEF];
  bit loaded [ATOM_SLOTS_DEF];
  int loaded_list [$];
  logic [BOX_W-1:0] box_len [3];
  res_t expected_distances [$];
  int errors;
  longint cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint min_image(input longint d, input longint box);
    if (2 * d > box) return d - box;
    if (2 * d < -box) return d + box;
    return d;
  endfunction

  function automatic longint floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic res_t pair_distance(input logic [IDX_W-1:0] ia,
                                         input logic [IDX_W-1:0] ib);
    res_t r;
    longint d;
    longint unsigned sum;
    sum = 0;
    d = min_image(longint'(atom_x[ia]) - longint'(atom_x[ib]), longint'(box_len[0]));
    sum += d * d;
    d = min_image(longint'(atom_y[ia]) - longint'(atom_y[ib]), longint'(box_len[1]));
    sum += d * d;
    d = min_image(longint'(atom_z[ia]) - longint'(atom_z[ib]), longint'(box_len[2]));
    sum += d * d;
    r.distance_sq = sum[DSQ_W-1:0];
    r.distance = DIST_W'(floor_root(sum));
    return r;
  endfunction

  // result checker with random stall
  initial begin
    int gap;
    res_t want;
    res_stall = 1;
    @(negedge rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 4) == 0) gap = 0;
      if (gap != 0) begin
        res_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      if (expected_distances.size() == 0) begin
        report("unexpected result", 64'(res_data.distance), 64'(0));
      end else begin
        want = expected_distances.pop_front();
        if (res_data.distance_sq !== want.distance_sq)
          report("distance_sq", 64'(res_data.distance_sq), 64'(want.distance_sq));
        if (res_data.distance !== want.distance)
          report("distance", 64'(res_data.distance), 64'(want.distance));
      end
    end
  end

  bit no_gaps;

  task automatic send(input req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    if (!no_gaps && $urandom_range(0, 2) == 0) gap = 0;
    if (gap != 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_data <= r;
    req_valid <= 1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (r.req_type == REQ_LOAD) begin
      atom_x[r.load_index] = r.pos_x;
      atom_y[r.load_index] = r.pos_y;
      atom_z[r.load_index] = r.pos_z;
      if (!loaded[r.load_index]) loaded_list.push_back(int'(r.load_index));
      loaded[r.load_index] = 1;
    end else begin
      expected_distances.push_back(pair_distance(r.first_atom, r.second_atom));
    end
  endtask

  task automatic load_atom(input int idx, input logic [POS_W-1:0] x,
                           input logic [POS_W-1:0] y, input logic [POS_W-1:0] z);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_LOAD;
    r.load_index = IDX_W'(idx);
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    send(r);
  endtask

  task automatic query_pair(input int ia, input int ib);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_QUERY;
    r.first_atom = IDX_W'(ia);
    r.second_atom = IDX_W'(ib);
    send(r);
  endtask

  task automatic drain;
    req_valid <= 0;
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_box(input logic [1:0] idx, input logic [BOX_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    box_len[idx] = v;
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
  endfunction

  task automatic test_extremes;
    load_atom(0, 24'h7FFFFF, 24'h800000, 24'h000000);
    load_atom(1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
    load_atom(1023, 24'h000000, 24'h000000, 24'h000000);
    load_atom(512, 24'd204800, -24'sd204800, 24'd204801);
    load_atom(513, 24'd0, 24'd0, -24'sd204800);
    query_pair(0, 1);
    query_pair(1, 0);
    query_pair(0, 0);
    query_pair(512, 1023);
    query_pair(1023, 512);
    query_pair(512, 513);
    query_pair(513, 512);
    query_pair(0, 1023);
    query_pair(1, 1023);
  endtask

  task automatic test_box_settings;
    logic [BOX_W-1:0] v [3];
    for (int s = 0; s < 5; s++) begin
      drain();
      for (int a = 0; a < 3; a++) begin
        case (s)
          0: v[a] = 23'd0;
          1: v[a] = 23'h7FFFFF;
          2: v[a] = 23'd1;
          3: v[a] = BOX_W'($urandom_range(1, 23'h7FFFFF));
          default: v[a] = BOX_RESET;
        endcase
      end
      set_box(CFG_BOX_X, v[0]);
      set_box(CFG_BOX_Y, v[1]);
      set_box(CFG_BOX_Z, v[2]);
      for (int i = 0; i < 10; i++) query_pair(pick_loaded(), pick_loaded());
    end
  endtask

  task automatic test_random(input int n);
    logic [POS_W-1:0] c [3];
    for (int i = 0; i < n; i++) begin
      if (i % 400 == 200) begin
        drain();
        set_box(CFG_BOX_X, BOX_W'($urandom_range(0, 23'h7FFFFF)));
        set_box(CFG_BOX_Y, BOX_W'($urandom_range(0, 1000000)));
        set_box(CFG_BOX_Z, BOX_W'($urandom_range(0, 23'h7FFFFF)));
      end
      if ($urandom_range(0, 2) == 0) begin
        for (int a = 0; a < 3; a++) begin
          c[a] = POS_W'($urandom);
          if ($urandom_range(0, 1)) c[a] = $signed(c[a]) >>> $urandom_range(0, 14);
        end
        load_atom($urandom_range(0, 1023), c[0], c[1], c[2]);
      end else begin
        query_pair(pick_loaded(), pick_loaded());
      end
    end
  endtask

  task automatic test_burst;
    drain();
    no_gaps = 1;
    for (int i = 0; i < 40; i++) query_pair(pick_loaded(), pick_loaded());
    for (int i = 0; i < 20; i++)
      load_atom($urandom_range(0, 1023), POS_W'($urandom), POS_W'($urandom),
                POS_W'($urandom));
    no_gaps = 0;
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_BOX_X;
    cfg_data = '0;
    req_valid = 0;
    req_data = '0;
    errors = 0;
    cycles = 0;
    no_gaps = 0;
    for (int a = 0; a < 3; a++) box_len[a] = BOX_RESET;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_box_settings();
    test_burst();
    test_random(1850);
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ppd_pkg.sv
sv/ppd_front.sv
sv/ppd_queue.sv
sv/ppd_back.sv
sv/periodic_pair_distance_core.sv
tb/tb_top.sv
